@@ sv/utf8v_pkg.sv @@
// shared types, codes and constants for the utf-8 stream validator
// no dependencies; imported by every module of the block
package utf8v_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int LEN_W           = 32;
  localparam int CP_W            = 21;
  localparam int DATA_W          = 8;
  localparam int TDATA_OUT_W     = 40;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_PLAIN   = 2'd0,
    STATUS_BOM     = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  // byte-order mark match progress
  typedef enum logic [2:0] {
    MARK_NONE   = 3'd0,
    MARK_ONE    = 3'd1,
    MARK_TWO    = 3'd2,
    MARK_FULL   = 3'd3,
    MARK_FAILED = 3'd4
  } mark_t;

  typedef struct packed {
    logic [1:0]      pending;
    logic [1:0]      seq_len;
    logic [CP_W-1:0] cp;
    logic            err;
    mark_t           mark;
  } dec_state_t;

  localparam dec_state_t DEC_RESET = '{
    pending: 2'd0,
    seq_len: 2'd0,
    cp:      '0,
    err:     1'b0,
    mark:    MARK_NONE
  };

  typedef struct packed {
    status_t          status;
    logic             bom;
    logic [LEN_W-1:0] len;
  } result_t;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_LO    = 8'hC2;
  localparam logic [7:0] LEAD2_HI    = 8'hDF;
  localparam logic [7:0] LEAD3_LO    = 8'hE0;
  localparam logic [7:0] LEAD3_HI    = 8'hEF;
  localparam logic [7:0] LEAD4_LO    = 8'hF0;
  localparam logic [7:0] LEAD4_HI    = 8'hF4;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_TAG    = 8'h80;
  localparam logic [7:0] BOM_BYTE0   = 8'hEF;
  localparam logic [7:0] BOM_BYTE1   = 8'hBB;
  localparam logic [7:0] BOM_BYTE2   = 8'hBF;
  localparam int         BOM_LEN     = 3;

  localparam logic [CP_W-1:0] CP_MIN2    = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN3    = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN4    = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;

endpackage

@@ sv/utf8v_byte_check.sv @@
// next decoder state for one data byte: sequence checks and mark tracking
// depends on utf8v_pkg
module utf8v_byte_check (
  input  utf8v_pkg::dec_state_t cur,
  input  logic [7:0]            data_byte,
  output utf8v_pkg::dec_state_t nxt
);
  import utf8v_pkg::*;

  logic [CP_W-1:0] cp_new;
  logic [1:0]      pend_dec;
  logic            cp_bad;

  assign cp_new   = {cur.cp[CP_W-7:0], data_byte[5:0]};
  assign pend_dec = cur.pending - 2'd1;

  // overlong, surrogate or out-of-range code point once the sequence closes
  assign cp_bad = (cur.seq_len == 2'd1 && cp_new < CP_MIN2) ||
                  (cur.seq_len == 2'd2 && cp_new < CP_MIN3) ||
                  (cur.seq_len == 2'd3 && cp_new < CP_MIN4) ||
                  (cp_new > CP_MAX) ||
                  (cp_new >= SURR_LO && cp_new <= SURR_HI);

  always_comb begin
    nxt = cur;
    if (!cur.err) begin
      if (cur.pending != 2'd0) begin
        if ((data_byte & CONT_MASK) != CONT_TAG) begin
          nxt.err     = 1'b1;
          nxt.pending = 2'd0;
        end else begin
          nxt.cp      = cp_new;
          nxt.pending = pend_dec;
          if (pend_dec == 2'd0 && cp_bad) begin
            nxt.err = 1'b1;
          end
        end
      end else if (data_byte < ASCII_LIMIT) begin
        if (data_byte == 8'h00) begin
          nxt.err = 1'b1;
        end
      end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
        nxt.seq_len = 2'd1;
        nxt.pending = 2'd1;
        nxt.cp      = {16'd0, data_byte[4:0]};
      end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
        nxt.seq_len = 2'd2;
        nxt.pending = 2'd2;
        nxt.cp      = {17'd0, data_byte[3:0]};
      end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
        nxt.seq_len = 2'd3;
        nxt.pending = 2'd3;
        nxt.cp      = {18'd0, data_byte[2:0]};
      end else begin
        nxt.err = 1'b1;
      end
    end

    case (cur.mark)
      MARK_NONE: nxt.mark = (data_byte == BOM_BYTE0) ? MARK_ONE  : MARK_FAILED;
      MARK_ONE:  nxt.mark = (data_byte == BOM_BYTE1) ? MARK_TWO  : MARK_FAILED;
      MARK_TWO:  nxt.mark = (data_byte == BOM_BYTE2) ? MARK_FULL : MARK_FAILED;
      default:   nxt.mark = cur.mark;
    endcase
  end

endmodule

@@ sv/utf8v_out_reg.sv @@
// result register on the output stream, takes a new result while the old one leaves
// depends on utf8v_pkg
module utf8v_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  utf8v_pkg::result_t din,
  input  logic               tready,
  output logic               tvalid,
  output utf8v_pkg::result_t dout,
  output logic               free
);
  import utf8v_pkg::*;

  assign free = !tvalid || tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (free) begin
      tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      dout <= din;
    end
  end

endmodule

@@ sv/utf8_stream_validator.sv @@
// utf-8 stream validator top level: input register, decoder state, result register
// depends on utf8v_pkg, utf8v_byte_check, utf8v_out_reg
// throughput: one transaction per cycle, data bytes and end items alike, while m_tready is high
// the verdict forms from the decoder state while the end item sits in the input register;
// it is loaded into the result register, setting m_tvalid, once that register has room
// reset: synchronous, clears the input and result valids, the decoder state and byte count
module utf8_stream_validator #(
  parameter int COUNT_WIDTH = utf8v_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] kind: 0 data byte, 1 end of buffer
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [1:0] status, [2] bom_present, [34:3] stripped_length,
                                 // [39:35] zero
);
  import utf8v_pkg::*;

  // length arithmetic is done at least 33 bits wide so overflow past 32 bits is visible
  localparam int EXT_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W + 1;

  // input register
  logic       in_valid;
  kind_t      in_kind;
  logic [7:0] in_byte;
  logic       in_advance;

  // running decoder state
  dec_state_t             dec;
  dec_state_t             dec_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;

  // result path
  result_t                res;
  result_t                out_res;
  logic                   out_free;
  logic                   is_bom;
  logic [COUNT_WIDTH-1:0] diff;
  logic [EXT_W-1:0]       diff_ext;
  logic                   len_sat;

  // a data byte always advances; an end item waits for room in the result register
  assign in_advance = in_valid && (in_kind == KIND_DATA || out_free);
  assign s_tready   = !in_valid || in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= kind_t'(s_tuser);
      in_byte <= s_tdata;
    end
  end

  utf8v_byte_check u_check (
    .cur       (dec),
    .data_byte (in_byte),
    .nxt       (dec_next)
  );

  // saturating byte count
  assign count_next = (&count) ? count : count + COUNT_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      dec   <= DEC_RESET;
      count <= '0;
    end else if (in_advance) begin
      if (in_kind == KIND_END) begin
        // end of buffer: everything starts over for the next buffer
        dec   <= DEC_RESET;
        count <= '0;
      end else begin
        dec   <= dec_next;
        count <= count_next;
      end
    end
  end

  // result from current state; mark present implies count is at least three
  assign is_bom   = (dec.mark == MARK_FULL);
  assign diff     = is_bom ? count - COUNT_WIDTH'(BOM_LEN) : count;
  assign diff_ext = EXT_W'(diff);
  assign len_sat  = (&count) || (|diff_ext[EXT_W-1:LEN_W]);

  always_comb begin
    res.bom = is_bom;
    res.len = len_sat ? {LEN_W{1'b1}} : diff_ext[LEN_W-1:0];
    if (dec.err || dec.pending != 2'd0) begin
      res.status = STATUS_INVALID;
    end else if (is_bom) begin
      res.status = STATUS_BOM;
    end else begin
      res.status = STATUS_PLAIN;
    end
  end

  utf8v_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (in_advance && in_kind == KIND_END),
    .din    (res),
    .tready (m_tready),
    .tvalid (m_tvalid),
    .dout   (out_res),
    .free   (out_free)
  );

  assign m_tdata = {5'd0, out_res.len, out_res.bom, out_res.status};

  // state is back at reset values after every end item
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    in_advance && in_kind == KIND_END |=> dec == DEC_RESET && count == '0)
    else $error("decoder state not cleared after end of buffer");

  // a result only appears after an end item went through
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_advance && in_kind == KIND_END))
    else $error("result appeared without an end item");

  // data bytes never produce a result
  a_data_no_load: assert property (@(posedge clk) disable iff (rst)
    in_advance && in_kind == KIND_DATA && out_free |=> !m_tvalid)
    else $error("result loaded by a data byte");

  // a detected mark never reports as plain valid
  a_bom_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.bom |-> out_res.status != STATUS_PLAIN)
    else $error("mark present but status says no mark");

  // a valid status with mark must carry the mark flag
  a_status_bom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.status == STATUS_BOM |-> out_res.bom)
    else $error("status says mark but flag is clear");

endmodule
